[hdl/sfd_pkg.sv]
`timescale 1ns / 1ps

package sfd_pkg;

	localparam logic [7:0] HDR0_BYTE = 8'h55;
	localparam logic [7:0] HDR1_BYTE = 8'hAA;
	localparam logic [7:0] TRL0_BYTE = 8'h0D;
	localparam logic [7:0] TRL1_BYTE = 8'h0A;
	localparam logic [15:0] CMD_RESET = 16'hA55A;
	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_CMD = 2'd1;
	localparam logic [1:0] ST_BAD_TRAILER = 2'd2;
	localparam logic [1:0] ST_BAD_CRC = 2'd3;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] payload_length;
		logic [31:0] left_speed_word;
		logic [31:0] right_speed_word;
	} sfd_result_t;

	// One byte through the reflected CRC-8, least significant bit first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	localparam logic [7:0] CRC_AFTER_HDR0 = crc8_step(8'h00, HDR0_BYTE);

endpackage

[hdl/sfd_frame_fsm.sv]
`timescale 1ns / 1ps

module sfd_frame_fsm (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] rx_byte,
	input logic [15:0] expected_command,
	output logic res_hit,
	output sfd_pkg::sfd_result_t result
);
	import sfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT0,
		PH_HUNT1,
		PH_CMD,
		PH_LEN,
		PH_PAYLOAD,
		PH_CRC,
		PH_TRAIL0,
		PH_TRAIL1
	} phase_t;

	phase_t phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] length_q, length_d;
	logic [15:0] cmd_q, cmd_d;
	logic [31:0] left_q, left_d;
	logic [31:0] right_q, right_d;
	logic [7:0] rcrc_q, rcrc_d;
	logic tbad_q, tbad_d;
	logic [7:0] crc_next;
	logic [7:0] count_inc;
	logic trailer_bad_now;

	assign crc_next = crc8_step(crc_q, rx_byte);
	assign count_inc = count_q + 8'd1;
	assign res_hit = (phase_q == PH_TRAIL1);
	assign trailer_bad_now = tbad_q | (rx_byte != TRL1_BYTE);

	always_comb begin
		result.payload_length = length_q;
		result.left_speed_word = left_q;
		result.right_speed_word = right_q;
		if (cmd_q != expected_command) begin
			result.status = ST_BAD_CMD;
		end else if (trailer_bad_now) begin
			result.status = ST_BAD_TRAILER;
		end else if (rcrc_q != crc_q) begin
			result.status = ST_BAD_CRC;
		end else begin
			result.status = ST_OK;
		end
	end

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		crc_d = crc_q;
		length_d = length_q;
		cmd_d = cmd_q;
		left_d = left_q;
		right_d = right_q;
		rcrc_d = rcrc_q;
		tbad_d = tbad_q;
		if (step) begin
			case (phase_q)
				PH_HUNT0, PH_HUNT1: begin
					if (phase_q == PH_HUNT1 && rx_byte == HDR1_BYTE) begin
						crc_d = crc_next;
						phase_d = PH_CMD;
						count_d = 8'd0;
					end else if (rx_byte == HDR0_BYTE) begin
						phase_d = PH_HUNT1;
						crc_d = CRC_AFTER_HDR0;
						count_d = 8'd0;
						length_d = 8'd0;
						cmd_d = 16'd0;
						left_d = 32'd0;
						right_d = 32'd0;
						rcrc_d = 8'd0;
						tbad_d = 1'b0;
					end else begin
						phase_d = PH_HUNT0;
					end
				end
				PH_CMD: begin
					crc_d = crc_next;
					if (!count_q[0]) begin
						cmd_d = {8'd0, rx_byte};
						count_d = 8'd1;
					end else begin
						cmd_d = {rx_byte, cmd_q[7:0]};
						count_d = 8'd0;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					crc_d = crc_next;
					length_d = rx_byte;
					count_d = 8'd0;
					phase_d = (rx_byte == 8'd0) ? PH_CRC : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					crc_d = crc_next;
					if (count_q[7:3] == 5'd0) begin
						if (!count_q[2]) begin
							left_d[{count_q[1:0], 3'b000} +: 8] = rx_byte;
						end else begin
							right_d[{count_q[1:0], 3'b000} +: 8] = rx_byte;
						end
					end
					if (count_inc == length_q) begin
						phase_d = PH_CRC;
					end
					count_d = count_inc;
				end
				PH_CRC: begin
					rcrc_d = rx_byte;
					phase_d = PH_TRAIL0;
				end
				PH_TRAIL0: begin
					tbad_d = (rx_byte != TRL0_BYTE);
					phase_d = PH_TRAIL1;
				end
				PH_TRAIL1: begin
					tbad_d = trailer_bad_now;
					phase_d = PH_HUNT0;
					count_d = 8'd0;
				end
				default: begin
					phase_d = PH_HUNT0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			count_q <= 8'd0;
			crc_q <= 8'd0;
			length_q <= 8'd0;
			cmd_q <= 16'd0;
			left_q <= 32'd0;
			right_q <= 32'd0;
			rcrc_q <= 8'd0;
			tbad_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			crc_q <= crc_d;
			length_q <= length_d;
			cmd_q <= cmd_d;
			left_q <= left_d;
			right_q <= right_d;
			rcrc_q <= rcrc_d;
			tbad_q <= tbad_d;
		end
	end

`ifndef SYNTH
	a_trail1_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_TRAIL1 |=> phase_q == PH_HUNT0)
		else $error("Receiver did not resume hunting after a frame.");

	a_count_below_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q < length_q)
		else $error("Payload count ran past the frame length.");

	a_hunt1_crc_seed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT1 |-> crc_q == CRC_AFTER_HDR0)
		else $error("CRC is not seeded by the first header byte.");

	a_zero_length_skips_payload: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_LEN && rx_byte == 8'd0 |=> phase_q == PH_CRC)
		else $error("Zero-length frame did not go straight to the CRC byte.");
`endif

endmodule

[hdl/serial_frame_deframer_crc8.sv]
`timescale 1ns / 1ps

// Byte-serial frame receiver. Each item is one received byte; the block takes one item
// per clock cycle and holds it in an input register, where the frame state machine and
// the CRC-8 update consume it. A result item is registered into an output register
// when the frame state machine consumes the second trailer byte, and waits there; the
// input side only stops when that register is still full and the next byte would produce
// another result. Writes to expected_command through cfg_we and cfg_wdata are registered.
module serial_frame_deframer_crc8 (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] status,
	output logic [7:0] payload_length,
	output logic [31:0] left_speed_word,
	output logic [31:0] right_speed_word
);
	import sfd_pkg::*;

	logic [15:0] expected_command_q;
	logic valid_s1;
	logic [7:0] rx_byte_s1;
	logic out_valid_q;
	sfd_result_t result_q;
	sfd_result_t fsm_result;
	logic res_hit;
	logic out_free;
	logic step;

	assign out_free = !out_valid_q || out_ready;
	assign step = valid_s1 && (!res_hit || out_free);
	assign in_ready = !valid_s1 || step;

	sfd_frame_fsm u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(rx_byte_s1),
		.expected_command(expected_command_q),
		.res_hit(res_hit),
		.result(fsm_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_command_q <= CMD_RESET;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				expected_command_q <= cfg_wdata;
			end
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step && res_hit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
		if (step && res_hit) begin
			result_q <= fsm_result;
		end
	end

	assign out_valid = out_valid_q;
	assign status = result_q.status;
	assign payload_length = result_q.payload_length;
	assign left_speed_word = result_q.left_speed_word;
	assign right_speed_word = result_q.right_speed_word;

endmodule
